// ===== rtl/qclt_pkg.sv =====
`default_nettype none
package qclt_pkg;

	localparam int unsigned MaxRes = 3;

	typedef enum logic [2:0] {
		K_CHAR   = 3'd0,
		K_WEND   = 3'd1,
		K_OK     = 3'd2,
		K_OPERR  = 3'd3,
		K_UNTERM = 3'd4,
		K_EMPTY  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		Q_PLAIN  = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} qmode_t;

	localparam logic [7:0] C_BSLASH = 8'h5C;
	localparam logic [7:0] C_SQUOTE = 8'h27;
	localparam logic [7:0] C_DQUOTE = 8'h22;
	localparam logic [7:0] C_PIPE   = 8'h7C;
	localparam logic [7:0] C_AMP    = 8'h26;
	localparam logic [7:0] C_SEMI   = 8'h3B;
	localparam logic [7:0] C_LT     = 8'h3C;
	localparam logic [7:0] C_GT     = 8'h3E;
	localparam logic [7:0] C_BTICK  = 8'h60;
	localparam logic [7:0] C_DOLLAR = 8'h24;
	localparam logic [7:0] C_SPACE  = 8'h20;
	localparam logic [7:0] C_TAB    = 8'h09;
	localparam logic [7:0] C_CR     = 8'h0D;

	// All results caused by one item.
	typedef struct packed {
		logic [1:0]            cnt;
		kind_t [MaxRes-1:0]    kind;
		logic [MaxRes-1:0][7:0] ch;
	} bundle_t;

	// Queue status seen by the back end.
	typedef struct packed {
		logic    empty;
		bundle_t head;
	} qstat_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == C_SPACE) || (c >= C_TAB && c <= C_CR);
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return (c == C_PIPE) || (c == C_AMP) || (c == C_SEMI) || (c == C_LT) ||
			(c == C_GT) || (c == C_BTICK) || (c == C_DOLLAR);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/qclt_front.sv =====
`default_nettype none
module qclt_front import qclt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] char_code,
	input  wire logic       end_mark,
	output bundle_t         bundle,
	output logic            has_res
);

	qmode_t qm_q, qm_d;
	logic esc_q, esc_d, open_q, open_d, seen_q, seen_d, fail_q, fail_d;
	logic [1:0] n;

	always_comb begin
		bundle = '0;
		n      = 2'd0;
		qm_d   = qm_q;
		esc_d  = esc_q;
		open_d = open_q;
		seen_d = seen_q;
		fail_d = fail_q;
		if (end_mark) begin
			if (!fail_q) begin
				if (esc_q) begin
					bundle.kind[n] = K_CHAR;
					bundle.ch[n]   = C_BSLASH;
					n = n + 2'd1;
				end
				if (qm_q == Q_SINGLE || qm_q == Q_DOUBLE) begin
					bundle.kind[n] = K_UNTERM;
					n = n + 2'd1;
				end else begin
					if (open_q) begin
						bundle.kind[n] = K_WEND;
						n = n + 2'd1;
					end
					bundle.kind[n] = (open_q || seen_q) ? K_OK : K_EMPTY;
					n = n + 2'd1;
				end
			end
			qm_d   = Q_PLAIN;
			esc_d  = 1'b0;
			open_d = 1'b0;
			seen_d = 1'b0;
			fail_d = 1'b0;
		end else if (!fail_q) begin
			unique case (qm_q)
				Q_SINGLE: begin
					if (char_code == C_SQUOTE) begin
						qm_d = Q_PLAIN;
					end else begin
						bundle.kind[n] = K_CHAR;
						bundle.ch[n]   = char_code;
						n = n + 2'd1;
					end
				end
				Q_DOUBLE: begin
					if (esc_q) begin
						if (char_code != C_DQUOTE && char_code != C_BSLASH) begin
							bundle.kind[n] = K_CHAR;
							bundle.ch[n]   = C_BSLASH;
							n = n + 2'd1;
						end
						bundle.kind[n] = K_CHAR;
						bundle.ch[n]   = char_code;
						n = n + 2'd1;
						esc_d = 1'b0;
					end else if (char_code == C_BSLASH) begin
						esc_d = 1'b1;
					end else if (char_code == C_DQUOTE) begin
						qm_d = Q_PLAIN;
					end else begin
						bundle.kind[n] = K_CHAR;
						bundle.ch[n]   = char_code;
						n = n + 2'd1;
					end
				end
				default: begin
					// plain; the unused fourth code behaves the same
					if (esc_q) begin
						open_d = 1'b1;
						bundle.kind[n] = K_CHAR;
						bundle.ch[n]   = char_code;
						n = n + 2'd1;
						esc_d = 1'b0;
					end else if (char_code == C_BSLASH) begin
						open_d = 1'b1;
						esc_d  = 1'b1;
					end else if (is_blank(char_code)) begin
						if (open_q) begin
							bundle.kind[n] = K_WEND;
							n = n + 2'd1;
							open_d = 1'b0;
							seen_d = 1'b1;
						end
					end else if (char_code == C_SQUOTE) begin
						open_d = 1'b1;
						qm_d   = Q_SINGLE;
					end else if (char_code == C_DQUOTE) begin
						open_d = 1'b1;
						qm_d   = Q_DOUBLE;
					end else if (is_oper(char_code)) begin
						bundle.kind[n] = K_OPERR;
						n = n + 2'd1;
						fail_d = 1'b1;
					end else begin
						open_d = 1'b1;
						bundle.kind[n] = K_CHAR;
						bundle.ch[n]   = char_code;
						n = n + 2'd1;
					end
				end
			endcase
		end
		bundle.cnt = n;
		has_res    = (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qm_q   <= Q_PLAIN;
			esc_q  <= 1'b0;
			open_q <= 1'b0;
			seen_q <= 1'b0;
			fail_q <= 1'b0;
		end else if (take) begin
			qm_q   <= qm_d;
			esc_q  <= esc_d;
			open_q <= open_d;
			seen_q <= seen_d;
			fail_q <= fail_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/qclt_fifo.sv =====
`default_nettype none
module qclt_fifo import qclt_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  bundle_t   wdata,
	input  wire logic rd,
	output logic      full,
	output qstat_t    stat
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	bundle_t mem_q [DEPTH];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [CntW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full       = (cnt_q == CntW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.head  = mem_q[rp_q];
	assign do_wr      = wr && !full;
	assign do_rd      = rd && !stat.empty;

	function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= bump(wp_q);
			end
			if (do_rd) begin
				rp_q <= bump(rp_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/qclt_back.sv =====
`default_nettype none
module qclt_back import qclt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  qstat_t          stat,
	output logic            q_rd,
	output logic            empty,
	input  wire logic       pop,
	output logic [2:0]      kind,
	output logic [7:0]      out_char,
	output logic            last
);

	logic       vld_q;
	kind_t      kind_q;
	logic [7:0] ch_q;
	logic       last_q;
	logic [1:0] idx_q;
	logic       load, fin;

	assign load  = !stat.empty && (!vld_q || pop);
	assign fin   = (idx_q == stat.head.cnt - 2'd1);
	assign q_rd  = load && fin;

	assign empty    = !vld_q;
	assign kind     = kind_q;
	assign out_char = ch_q;
	assign last     = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= stat.head.kind[idx_q];
			ch_q   <= stat.head.ch[idx_q];
			last_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= fin ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				vld_q <= 1'b0;
			end
		end
	end

	a_mid_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> !stat.empty && idx_q < stat.head.cnt)
		else $error("bundle index lost its head");
	a_head_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.empty |-> stat.head.cnt != 2'd0)
		else $error("empty bundle queued");
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && kind_q != K_CHAR |-> ch_q == 8'd0)
		else $error("non-char result carries a byte");

endmodule
`default_nettype wire

// ===== rtl/quoted_command_line_tokenizer_unit.sv =====
// The results of an item pass through the bundle queue and then the output register.
// Throughput: one item per cycle while the queue has room; the output register drains
// one result per cycle while popped, so items with two or three results fill the queue.
// Items with no result never enter the bundle queue. The bundle queue (DEPTH entries) sets full.
// Reset (arst_n low, asynchronous): plain mode, all line flags clear, queue and output empty.
`default_nettype none
module quoted_command_line_tokenizer_unit import qclt_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_code,
	input  wire logic       end_mark,
	output logic            empty,
	input  wire logic       pop,
	output logic [2:0]      kind,
	output logic [7:0]      out_char,
	output logic            last
);

	bundle_t bundle;
	logic    has_res;
	logic    take;
	logic    q_full;
	logic    q_rd;
	qstat_t  stat;

	// An item is taken whenever the queue has room; items giving no result
	// update the line state only.
	assign full = q_full;
	assign take = push && !q_full;

	// Front: quote/escape state machine, builds all results of an item at once.
	qclt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_code (char_code),
		.end_mark  (end_mark),
		.bundle    (bundle),
		.has_res   (has_res)
	);

	// Short queue of result bundles decouples the two halves.
	qclt_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take && has_res),
		.wdata  (bundle),
		.rd     (q_rd),
		.full   (q_full),
		.stat   (stat)
	);

	// Back: unpacks a bundle into single results behind an output register.
	qclt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.q_rd     (q_rd),
		.empty    (empty),
		.pop      (pop),
		.kind     (kind),
		.out_char (out_char),
		.last     (last)
	);

endmodule
`default_nettype wire
